// ===== hw/rtl/tces_pkg.sv =====
// Shared constants, register indexes and control structs for the touch
// coordinate edge snap block. No dependencies.
package tces_pkg;

    localparam int FINGER_SLOTS = 2;
    localparam int SLOT_W       = 1;
    localparam int COORD_W      = 12;
    localparam int POS_W        = 14;
    localparam int PRESS_W      = 8;
    localparam int NIB_W        = 4;
    localparam int OUT_W        = 16;
    localparam int MODE_W       = 4;
    localparam int TH_W         = 4 * COORD_W;
    localparam int TGT_W        = 14;
    localparam int SNAP_W       = 4 * TGT_W;
    localparam int SCALE_X      = 320;
    localparam int SCALE_Y      = 540;
    // magnitude of (14-bit signed position) * 540 fits in 23 bits
    localparam int MAG_W        = 23;
    localparam int CNT_W        = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = SNAP_W;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TH_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TH_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP   = 3'd5;

    localparam logic [COORD_W-1:0] MAX_RESET = 12'd4095;

    typedef struct packed {
        logic load_in;
        logic snap;
        logic mul;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

// ===== hw/rtl/tces_if.sv =====
// Valid/ready channel interfaces for finger samples and processed results.
// Depends on tces_pkg.
interface tces_sample_if;
    logic                              valid;
    logic                              ready;
    logic [tces_pkg::SLOT_W-1:0]       slot;
    logic [tces_pkg::COORD_W-1:0]      raw_x;
    logic [tces_pkg::COORD_W-1:0]      raw_y;
    logic [tces_pkg::PRESS_W-1:0]      pressure;
    logic [tces_pkg::NIB_W-1:0]        width_x;
    logic [tces_pkg::NIB_W-1:0]        width_y;
    logic                              frame_end;

    modport source (output valid, slot, raw_x, raw_y, pressure, width_x, width_y,
                    frame_end, input ready);
    modport sink   (input valid, slot, raw_x, raw_y, pressure, width_x, width_y,
                    frame_end, output ready);
endinterface

interface tces_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [tces_pkg::OUT_W-1:0] pos_x;
    logic signed [tces_pkg::OUT_W-1:0] pos_y;
    logic [tces_pkg::PRESS_W-1:0]      touch_pressure;
    logic [tces_pkg::NIB_W-1:0]        touch_width;
    logic                              frame_last;

    modport source (output valid, pos_x, pos_y, touch_pressure, touch_width,
                    frame_last, input ready);
    modport sink   (input valid, pos_x, pos_y, touch_pressure, touch_width,
                    frame_last, output ready);
endinterface

// ===== hw/rtl/tces_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tces_pkg.
module tces_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tces_pkg::MAG_W-1:0]    dividend,
    input  logic [tces_pkg::COORD_W-1:0]  divisor,
    output logic [tces_pkg::MAG_W-1:0]    quotient,
    output logic                          busy
);

    logic [tces_pkg::COORD_W-1:0] rem_reg, rem_next;
    logic [tces_pkg::MAG_W-1:0]   quo_reg, quo_next;
    logic [tces_pkg::COORD_W-1:0] div_reg, div_next;
    logic [tces_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic [tces_pkg::COORD_W:0]   shifted;
    logic [tces_pkg::COORD_W:0]   diff;
    logic                         fits;

    assign shifted = {rem_reg, quo_reg[tces_pkg::MAG_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits COORD_W bits
            rem_next = fits ? diff[tces_pkg::COORD_W-1:0] : shifted[tces_pkg::COORD_W-1:0];
            quo_next = {quo_reg[tces_pkg::MAG_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tces_pkg::CNT_W'(tces_pkg::MAG_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

// ===== hw/rtl/tces_ctrl.sv =====
// Sequencer for one finger sample: capture, snap, multiply, divide, deliver.
// Depends on tces_pkg.
module tces_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output tces_pkg::cmd_t    cmd,
    input  tces_pkg::status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SNAP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SNAP;
                end
            end
            S_SNAP:
            begin
                cmd.snap   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ===== hw/rtl/tces_dp.sv =====
// Datapath: configuration registers, mirror and snap with per-slot latches,
// scaling multiply, two dividers and saturation. Depends on tces_pkg, tces_div.
module tces_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tces_pkg::cmd_t                        cmd,
    output tces_pkg::status_t                     status,
    input  logic                                  cfg_we,
    input  logic [tces_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tces_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [tces_pkg::SLOT_W-1:0]           slot,
    input  logic [tces_pkg::COORD_W-1:0]          raw_x,
    input  logic [tces_pkg::COORD_W-1:0]          raw_y,
    input  logic [tces_pkg::PRESS_W-1:0]          pressure,
    input  logic [tces_pkg::NIB_W-1:0]            width_x,
    input  logic [tces_pkg::NIB_W-1:0]            width_y,
    input  logic                                  frame_end,
    output logic signed [tces_pkg::OUT_W-1:0]     pos_x,
    output logic signed [tces_pkg::OUT_W-1:0]     pos_y,
    output logic [tces_pkg::PRESS_W-1:0]          touch_pressure,
    output logic [tces_pkg::NIB_W-1:0]            touch_width,
    output logic                                  frame_last
);

    typedef struct packed {
        logic signed [tces_pkg::POS_W-1:0] p;
        logic                              next;
    } snap_res_t;

    function automatic snap_res_t snap_axis(
        input logic signed [tces_pkg::POS_W-1:0] p,
        input logic [tces_pkg::TH_W-1:0]         th,
        input logic signed [tces_pkg::TGT_W-1:0] lo_t,
        input logic signed [tces_pkg::TGT_W-1:0] hi_t,
        input logic                              latched
    );
        snap_res_t                         r;
        logic signed [tces_pkg::POS_W-1:0] lo_on, lo_off, hi_on, hi_off;
        lo_on  = $signed({2'b00, th[11:0]});
        lo_off = $signed({2'b00, th[23:12]});
        hi_on  = $signed({2'b00, th[35:24]});
        hi_off = $signed({2'b00, th[47:36]});
        r.p    = p;
        r.next = latched;
        if (latched)
        begin
            if (p <= lo_off)
                r.p = lo_t;
            else if (p >= hi_off)
                r.p = hi_t;
            else
                r.next = 1'b0;
        end
        else
        begin
            if (p <= lo_on)
            begin
                r.p    = lo_t;
                r.next = 1'b1;
            end
            else if (p >= hi_on)
            begin
                r.p    = hi_t;
                r.next = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [tces_pkg::OUT_W-1:0] saturate(
        input logic [tces_pkg::MAG_W-1:0] q,
        input logic                       neg
    );
        logic [tces_pkg::OUT_W-1:0] r;
        if (!neg)
            r = (q > tces_pkg::MAG_W'(32767)) ? 16'h7fff : q[tces_pkg::OUT_W-1:0];
        else
            r = (q > tces_pkg::MAG_W'(32768)) ? 16'h8000 : (~q[tces_pkg::OUT_W-1:0] + 1'b1);
        return r;
    endfunction

    // configuration
    logic [tces_pkg::MODE_W-1:0]  mode_reg;
    logic [tces_pkg::COORD_W-1:0] max_x_reg, max_y_reg;
    logic [tces_pkg::TH_W-1:0]    th_x_reg, th_y_reg;
    logic [tces_pkg::SNAP_W-1:0]  targets_reg;

    // hysteresis latches, one per slot and axis
    logic [tces_pkg::FINGER_SLOTS-1:0] latch_x_reg, latch_y_reg;

    // captured sample
    logic [tces_pkg::SLOT_W-1:0]  slot_reg;
    logic [tces_pkg::COORD_W-1:0] raw_x_reg, raw_y_reg;
    logic [tces_pkg::PRESS_W-1:0] press_reg;
    logic [tces_pkg::NIB_W-1:0]   wx_reg, wy_reg;
    logic                         frame_reg;

    // pipeline of one item
    logic signed [tces_pkg::POS_W-1:0] p0_reg, p1_reg;
    logic [tces_pkg::MAG_W-1:0]        prod0_reg, prod1_reg;
    logic                              neg0_reg, neg1_reg;
    logic [tces_pkg::COORD_W-1:0]      dvs0_reg, dvs1_reg;

    // output payload
    logic [tces_pkg::OUT_W-1:0]   pos_x_reg, pos_y_reg;
    logic [tces_pkg::PRESS_W-1:0] out_press_reg;
    logic [tces_pkg::NIB_W-1:0]   out_width_reg;
    logic                         out_frame_reg;

    logic signed [tces_pkg::POS_W-1:0] mir_x, mir_y, pos0, pos1;
    snap_res_t                         snap_x, snap_y;
    logic                              slot_ok, lat_x, lat_y;
    logic [tces_pkg::POS_W-1:0]        mag0, mag1;
    logic [tces_pkg::MAG_W-1:0]        prod0, prod1, q0, q1;
    logic [tces_pkg::NIB_W:0]          wsum;
    logic                              busy0, busy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            max_x_reg   <= tces_pkg::MAX_RESET;
            max_y_reg   <= tces_pkg::MAX_RESET;
            th_x_reg    <= '0;
            th_y_reg    <= '0;
            targets_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tces_pkg::REG_MODE:  mode_reg    <= cfg_data[tces_pkg::MODE_W-1:0];
                tces_pkg::REG_MAX_X: max_x_reg   <= cfg_data[tces_pkg::COORD_W-1:0];
                tces_pkg::REG_MAX_Y: max_y_reg   <= cfg_data[tces_pkg::COORD_W-1:0];
                tces_pkg::REG_TH_X:  th_x_reg    <= cfg_data[tces_pkg::TH_W-1:0];
                tces_pkg::REG_TH_Y:  th_y_reg    <= cfg_data[tces_pkg::TH_W-1:0];
                tces_pkg::REG_SNAP:  targets_reg <= cfg_data[tces_pkg::SNAP_W-1:0];
                default: ;
            endcase
        end
    end

    // mirror, then snap against the latched state of this slot
    assign mir_x = mode_reg[0] ? ($signed({2'b00, max_x_reg}) - $signed({2'b00, raw_x_reg}))
                               : $signed({2'b00, raw_x_reg});
    assign mir_y = mode_reg[1] ? ($signed({2'b00, max_y_reg}) - $signed({2'b00, raw_y_reg}))
                               : $signed({2'b00, raw_y_reg});

    assign slot_ok = (int'(slot_reg) < tces_pkg::FINGER_SLOTS);
    assign lat_x   = slot_ok && latch_x_reg[slot_reg];
    assign lat_y   = slot_ok && latch_y_reg[slot_reg];

    assign snap_x = snap_axis(mir_x, th_x_reg, $signed(targets_reg[13:0]),
                              $signed(targets_reg[27:14]), lat_x);
    assign snap_y = snap_axis(mir_y, th_y_reg, $signed(targets_reg[41:28]),
                              $signed(targets_reg[55:42]), lat_y);

    always_comb
    begin
        pos0 = mode_reg[2] ? snap_x.p : mir_x;
        pos1 = mode_reg[2] ? snap_y.p : mir_y;
        if (mode_reg[3])
        begin
            pos0 = mode_reg[2] ? snap_y.p : mir_y;
            pos1 = mode_reg[2] ? snap_x.p : mir_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_x_reg <= '0;
            latch_y_reg <= '0;
        end
        else if (cmd.snap && mode_reg[2] && slot_ok)
        begin
            latch_x_reg[slot_reg] <= snap_x.next;
            latch_y_reg[slot_reg] <= snap_y.next;
        end
    end

    // sign-magnitude multiply by the screen span
    assign mag0  = p0_reg[tces_pkg::POS_W-1] ? (~p0_reg + 1'b1) : p0_reg;
    assign mag1  = p1_reg[tces_pkg::POS_W-1] ? (~p1_reg + 1'b1) : p1_reg;
    assign prod0 = tces_pkg::MAG_W'(mag0) * tces_pkg::MAG_W'(tces_pkg::SCALE_X);
    assign prod1 = tces_pkg::MAG_W'(mag1) * tces_pkg::MAG_W'(tces_pkg::SCALE_Y);

    assign wsum = {1'b0, wx_reg} + {1'b0, wy_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            slot_reg  <= slot;
            raw_x_reg <= raw_x;
            raw_y_reg <= raw_y;
            press_reg <= pressure;
            wx_reg    <= width_x;
            wy_reg    <= width_y;
            frame_reg <= frame_end;
        end
        if (cmd.snap)
        begin
            p0_reg <= pos0;
            p1_reg <= pos1;
        end
        if (cmd.mul)
        begin
            prod0_reg <= prod0;
            prod1_reg <= prod1;
            neg0_reg  <= p0_reg[tces_pkg::POS_W-1];
            neg1_reg  <= p1_reg[tces_pkg::POS_W-1];
            // a zero maximum divides as one
            dvs0_reg  <= (max_x_reg == '0) ? tces_pkg::COORD_W'(1) : max_x_reg;
            dvs1_reg  <= (max_y_reg == '0) ? tces_pkg::COORD_W'(1) : max_y_reg;
        end
        if (cmd.load_out)
        begin
            pos_x_reg     <= saturate(q0, neg0_reg);
            pos_y_reg     <= saturate(q1, neg1_reg);
            out_press_reg <= press_reg;
            out_width_reg <= wsum[tces_pkg::NIB_W:1];
            out_frame_reg <= frame_reg;
        end
    end

    tces_div u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod0_reg),
        .divisor  (dvs0_reg),
        .quotient (q0),
        .busy     (busy0)
    );

    tces_div u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod1_reg),
        .divisor  (dvs1_reg),
        .quotient (q1),
        .busy     (busy1)
    );

    assign status.div_done = !busy0 && !busy1;

    assign pos_x          = $signed(pos_x_reg);
    assign pos_y          = $signed(pos_y_reg);
    assign touch_pressure = out_press_reg;
    assign touch_width    = out_width_reg;
    assign frame_last     = out_frame_reg;

endmodule

// ===== hw/rtl/touch_coordinate_edge_snap.sv =====
// Each accepted sample is captured, snapped, scaled, divided and saturated into the output.
// The 23-step restoring dividers pace items; no new sample is taken until the output loads.
// One item is in work at a time; a finished result waits in the output register.
// Reset (rst_n, async, low): config to defaults, snap latches cleared, idle.
// Depends on tces_pkg, tces_if, tces_ctrl, tces_dp.
module touch_coordinate_edge_snap (
    input  logic                              clk,
    input  logic                              rst_n,
    tces_sample_if.sink                       sample,
    tces_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [tces_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tces_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Controller and datapath talk only through the command and status structs.
    tces_pkg::cmd_t    cmd;
    tces_pkg::status_t status;

    // Sequence per item: capture, mirror, snap (updates latches in snap mode) and swap,
    // multiply, run both axis dividers in parallel, saturate into the output.
    tces_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    // Config writes land directly in the datapath's registers; they are
    // expected only while no item is in work.
    tces_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .slot           (sample.slot),
        .raw_x          (sample.raw_x),
        .raw_y          (sample.raw_y),
        .pressure       (sample.pressure),
        .width_x        (sample.width_x),
        .width_y        (sample.width_y),
        .frame_end      (sample.frame_end),
        .pos_x          (result.pos_x),
        .pos_y          (result.pos_y),
        .touch_pressure (result.touch_pressure),
        .touch_width    (result.touch_width),
        .frame_last     (result.frame_last)
    );

endmodule

// ===== hw/rtl/tces_checker.sv =====
// Port-level checks for touch_coordinate_edge_snap, attached by bind.
// Depends on tces_pkg.
module tces_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [tces_pkg::OUT_W-1:0]    result_pos_x,
    input logic [tces_pkg::OUT_W-1:0]    result_pos_y
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_pos_x) && $stable(result_pos_y))
        else $error("result payload changed while stalled");

    // one item in work: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second item accepted while one is in work");

    // a new result only comes from the busy sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result appeared without an item in work");

endmodule

bind touch_coordinate_edge_snap tces_checker u_tces_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_pos_x (result.pos_x),
    .result_pos_y (result.pos_y)
);

// ===== dv/touch_coordinate_edge_snap_tb.sv =====
// Self-checking testbench for touch_coordinate_edge_snap: a directed table, then random finger
// traces, each result checked against an in-bench model of mirror, edge snap, swap and scale or a hand-typed value.
// Depends on tces_pkg, tces_if and the block's RTL.
`timescale 1ns / 1ps

module touch_coordinate_edge_snap_tb;
    import tces_pkg::*;

    // Mode register bits
    localparam logic [MODE_W-1:0] MODE_FLIP_X = 4'b0001;
    localparam logic [MODE_W-1:0] MODE_FLIP_Y = 4'b0010;
    localparam logic [MODE_W-1:0] MODE_SNAP   = 4'b0100;
    localparam logic [MODE_W-1:0] MODE_SWAP   = 4'b1000;
    localparam logic [MODE_W-1:0] MODE_ALL    = 4'b1111;

    // Indexes past the last register; the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int MAX_SHOWN       = 10;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int COORD_TOP       = 4095;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic [PRESS_W-1:0] pressure;
        logic [NIB_W-1:0]   width_x;
        logic [NIB_W-1:0]   width_y;
        logic               frame_end;
    } finger_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos_x;
        logic signed [OUT_W-1:0] pos_y;
        logic [PRESS_W-1:0]      touch_pressure;
        logic [NIB_W-1:0]        touch_width;
        logic                    frame_last;
    } touch_t;

    // One row of the directed table: either a register write or a finger item,
    // optionally with its result typed in by hand.
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        finger_t               smp;
        bit                    fixed;
        touch_t                want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  rdy_drive = 1'b0;

    tces_sample_if finger_ch ();
    tces_result_if touch_ch ();

    assign touch_ch.ready = rdy_drive;

    touch_coordinate_edge_snap uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (finger_ch),
        .result    (touch_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model state: a private copy of the registers and the snap latches
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  mdl_mode;
    logic [COORD_W-1:0] mdl_max_x;
    logic [COORD_W-1:0] mdl_max_y;
    logic [TH_W-1:0]    mdl_th_x;
    logic [TH_W-1:0]    mdl_th_y;
    logic [SNAP_W-1:0]  mdl_targets;
    bit                 mdl_latch [FINGER_SLOTS][2];

    touch_t pending_touch [$];      // results owed by the block, oldest first
    int     mismatch_cnt = 0;

    // Sender pacing
    int burst_left    = 1;
    bit sender_steady = 1'b0;

    // Receiver stall pattern
    bit          rdy_level = 1'b1;
    int          rdy_run   = 0;
    logic [15:0] rx_cycle  = '0;

    // Mirror, then snap with hysteresis, one axis. Returns the signed position.
    function automatic int edge_axis(int axis, logic [COORD_W-1:0] raw,
                                     logic [SLOT_W-1:0] slot);
        logic [TH_W-1:0]         th;
        logic signed [TGT_W-1:0] tgt_lo;
        logic signed [TGT_W-1:0] tgt_hi;
        int                      p;
        int                      amax;
        int                      lo_on;
        int                      lo_off;
        int                      hi_on;
        int                      hi_off;
        bit                      held;
        bit                      held_next;
        p    = int'(raw);
        amax = (axis != 0) ? int'(mdl_max_y) : int'(mdl_max_x);
        // mirrored value goes negative when the raw value exceeds the maximum
        if (mdl_mode[axis])
            p = amax - p;
        if ((mdl_mode & MODE_SNAP) != '0)
        begin
            th     = (axis != 0) ? mdl_th_y : mdl_th_x;
            tgt_lo = mdl_targets[(2 * axis) * TGT_W +: TGT_W];
            tgt_hi = mdl_targets[(2 * axis + 1) * TGT_W +: TGT_W];
            lo_on  = int'(th[0 +: COORD_W]);
            lo_off = int'(th[COORD_W +: COORD_W]);
            hi_on  = int'(th[2 * COORD_W +: COORD_W]);
            hi_off = int'(th[3 * COORD_W +: COORD_W]);
            // slot is one bit wide here, so it always names a real latch
            held      = mdl_latch[slot][axis];
            held_next = held;
            if (held)
            begin
                if (p <= lo_off)
                    p = int'(tgt_lo);
                else if (p >= hi_off)
                    p = int'(tgt_hi);
                else
                    held_next = 1'b0;
            end
            else
            begin
                if (p <= lo_on)
                begin
                    p         = int'(tgt_lo);
                    held_next = 1'b1;
                end
                else if (p >= hi_on)
                begin
                    p         = int'(tgt_hi);
                    held_next = 1'b1;
                end
            end
            mdl_latch[slot][axis] = held_next;
        end
        return p;
    endfunction

    // Scale by k / max with truncation toward zero; a zero maximum divides by one.
    function automatic logic signed [OUT_W-1:0] scale_clamp(int p, int k,
                                                            logic [COORD_W-1:0] m);
        int d;
        int q;
        d = (m == '0) ? 1 : int'(m);
        q = (p * k) / d;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[OUT_W-1:0];
    endfunction

    function automatic touch_t predict_touch(finger_t f);
        touch_t r;
        int     p0;
        int     p1;
        int     t;
        int     wsum;
        p0 = edge_axis(0, f.raw_x, f.slot);
        p1 = edge_axis(1, f.raw_y, f.slot);
        if ((mdl_mode & MODE_SWAP) != '0)
        begin
            t  = p0;
            p0 = p1;
            p1 = t;
        end
        wsum             = int'(f.width_x) + int'(f.width_y);
        r.pos_x          = scale_clamp(p0, SCALE_X, mdl_max_x);
        r.pos_y          = scale_clamp(p1, SCALE_Y, mdl_max_y);
        r.touch_pressure = f.pressure;
        r.touch_width    = NIB_W'(wsum / 2);
        r.frame_last     = f.frame_end;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:  mdl_mode    = data[MODE_W-1:0];
            REG_MAX_X: mdl_max_x   = data[COORD_W-1:0];
            REG_MAX_Y: mdl_max_y   = data[COORD_W-1:0];
            REG_TH_X:  mdl_th_x    = data[TH_W-1:0];
            REG_TH_Y:  mdl_th_y    = data[TH_W-1:0];
            REG_SNAP:  mdl_targets = data[SNAP_W-1:0];
            default:   ;    // spare index: no register behind it
        endcase
    endfunction

    // Thresholds pack as high off, high on, low off, low on from the top down.
    function automatic logic [TH_W-1:0] pack_th(int lo_on, int lo_off, int hi_on, int hi_off);
        return {COORD_W'(hi_off), COORD_W'(hi_on), COORD_W'(lo_off), COORD_W'(lo_on)};
    endfunction

    function automatic logic [SNAP_W-1:0] pack_targets(int x_lo, int x_hi, int y_lo, int y_hi);
        return {TGT_W'(y_hi), TGT_W'(y_lo), TGT_W'(x_hi), TGT_W'(x_lo)};
    endfunction

    function automatic logic [COORD_W-1:0] pick_max();
        int r;
        r = int'($urandom_range(0, 7));
        if (r == 0)
            return COORD_W'(COORD_TOP);
        if (r == 1)
            return COORD_W'($urandom_range(1, 64));
        return COORD_W'($urandom_range(256, COORD_TOP));
    endfunction

    // Mostly sane hysteresis bands near both edges, sometimes raw noise.
    function automatic logic [TH_W-1:0] pick_thresholds();
        logic [63:0] rnd;
        int          lo_on;
        int          hi_on;
        rnd = {$urandom, $urandom};
        if ($urandom_range(0, 4) == 0)
            return rnd[TH_W-1:0];
        lo_on = int'($urandom_range(0, 600));
        hi_on = int'($urandom_range(3400, COORD_TOP));
        return pack_th(lo_on, lo_on + int'($urandom_range(0, 300)),
                       hi_on, hi_on - int'($urandom_range(0, 300)));
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = data;
        r.smp      = '0;
        r.fixed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic stim_row_t finger_row(int sl, int x, int y, int pr,
                                             int wx, int wy, int fe);
        stim_row_t r;
        r.is_write        = 1'b0;
        r.idx             = '0;
        r.data            = '0;
        r.smp.slot        = SLOT_W'(sl);
        r.smp.raw_x       = COORD_W'(x);
        r.smp.raw_y       = COORD_W'(y);
        r.smp.pressure    = PRESS_W'(pr);
        r.smp.width_x     = NIB_W'(wx);
        r.smp.width_y     = NIB_W'(wy);
        r.smp.frame_end   = fe[0];
        r.fixed           = 1'b0;
        r.want            = '0;
        return r;
    endfunction

    function automatic stim_row_t with_want(stim_row_t r, int px, int py, int pr,
                                            int w, int fl);
        r.fixed                = 1'b1;
        r.want.pos_x           = OUT_W'(px);
        r.want.pos_y           = OUT_W'(py);
        r.want.touch_pressure  = PRESS_W'(pr);
        r.want.touch_width     = NIB_W'(w);
        r.want.frame_last      = fl[0];
        return r;
    endfunction

    // Drive a register write at the next edge and mirror it in the model.
    // The caller drops cfg_we once its group of writes is done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    // Offer one finger item, hold it until accepted, then log what it owes.
    // Between bursts, sometimes drop valid for a random gap.
    task automatic send_finger(finger_t f, bit fixed, touch_t want);
        touch_t model_out;
        int     gap;
        finger_ch.valid     <= 1'b1;
        finger_ch.slot      <= f.slot;
        finger_ch.raw_x     <= f.raw_x;
        finger_ch.raw_y     <= f.raw_y;
        finger_ch.pressure  <= f.pressure;
        finger_ch.width_x   <= f.width_x;
        finger_ch.width_y   <= f.width_y;
        finger_ch.frame_end <= f.frame_end;
        do
            @(posedge clk);
        while (finger_ch.ready !== 1'b1);
        // always run the model so the latches track, even for hand-typed rows
        model_out = predict_touch(f);
        pending_touch.push_back(fixed ? want : model_out);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = int'($urandom_range(1, 12));
            gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0
                                                                : int'($urandom_range(1, 40));
            if (gap > 0)
            begin
                finger_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering items and wait until every owed result has come back.
    task automatic settle_block();
        finger_ch.valid <= 1'b0;
        while (pending_touch.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_touch();
        touch_t got;
        touch_t want;
        got.pos_x          = touch_ch.pos_x;
        got.pos_y          = touch_ch.pos_y;
        got.touch_pressure = touch_ch.touch_pressure;
        got.touch_width    = touch_ch.touch_width;
        got.frame_last     = touch_ch.frame_last;
        if (pending_touch.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN)
                $display("%0t: result with nothing owed: pos %0d,%0d p=%0d w=%0d last=%0b",
                         $time, got.pos_x, got.pos_y, got.touch_pressure,
                         got.touch_width, got.frame_last);
        end
        else
        begin
            want = pending_touch.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
                || got.touch_pressure !== want.touch_pressure
                || got.touch_width !== want.touch_width
                || got.frame_last !== want.frame_last)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                begin
                    $write("%0t: expected pos %0d,%0d p=%0d w=%0d last=%0b,",
                           $time, want.pos_x, want.pos_y, want.touch_pressure,
                           want.touch_width, want.frame_last);
                    $display(" got pos %0d,%0d p=%0d w=%0d last=%0b",
                             got.pos_x, got.pos_y, got.touch_pressure,
                             got.touch_width, got.frame_last);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted item, then pick the next ready.
    // Ready runs high or low for random stretches; while rx_cycle bits 13:12
    // are both set, it never stalls at all.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (touch_ch.valid === 1'b1 && touch_ch.ready === 1'b1)
                check_touch();
            rx_cycle = rx_cycle + 16'd1;
            if (rdy_run == 0)
            begin
                rdy_level = ($urandom_range(0, 2) != 0);
                rdy_run   = rdy_level ? int'($urandom_range(1, 60))
                                      : int'($urandom_range(1, 35));
            end
            else
            begin
                rdy_run--;
            end
            rdy_drive <= rdy_level || (rx_cycle[13:12] == 2'b11);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random phases with fresh settings
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t         dir_tbl [$];
        finger_t           f;
        int                trace_x [FINGER_SLOTS];
        int                trace_y [FINGER_SLOTS];
        int                pick;
        int                s;
        logic [63:0]       rnd;
        logic [MODE_W-1:0] mode_sel;
        logic [COORD_W-1:0] mx;
        logic [COORD_W-1:0] my;
        logic [TH_W-1:0]   thx;
        logic [TH_W-1:0]   thy;
        logic [SNAP_W-1:0] tgts;

        // Known values on every input from time zero
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_MODE;
        cfg_data            = '0;
        finger_ch.valid     = 1'b0;
        finger_ch.slot      = '0;
        finger_ch.raw_x     = '0;
        finger_ch.raw_y     = '0;
        finger_ch.pressure  = '0;
        finger_ch.width_x   = '0;
        finger_ch.width_y   = '0;
        finger_ch.frame_end = 1'b0;

        // Model matches the block's reset values
        mdl_mode    = '0;
        mdl_max_x   = MAX_RESET;
        mdl_max_y   = MAX_RESET;
        mdl_th_x    = '0;
        mdl_th_y    = '0;
        mdl_targets = '0;
        foreach (mdl_latch[i, j])
            mdl_latch[i][j] = 1'b0;
        for (int k = 0; k < FINGER_SLOTS; k++)
        begin
            trace_x[k] = 2048;
            trace_y[k] = 2048;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: identity mapping, full-scale maxima
        dir_tbl.push_back(with_want(finger_row(0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
        dir_tbl.push_back(with_want(finger_row(1, 4095, 4095, 255, 15, 15, 1),
                                    320, 540, 255, 15, 1));
        dir_tbl.push_back(finger_row(0, 2048, 1, 128, 15, 0, 0));
        // Mirror both axes
        dir_tbl.push_back(reg_row(REG_MODE, CFG_DATA_W'(MODE_FLIP_X | MODE_FLIP_Y)));
        dir_tbl.push_back(with_want(finger_row(1, 0, 0, 1, 1, 0, 1), 320, 540, 1, 0, 1));
        dir_tbl.push_back(with_want(finger_row(0, 4095, 4095, 254, 8, 8, 0), 0, 0, 254, 8, 0));
        // Zero x maximum scales as one but mirrors as zero; saturate both ways
        dir_tbl.push_back(reg_row(REG_MAX_X, '0));
        dir_tbl.push_back(reg_row(REG_MAX_Y, CFG_DATA_W'(1)));
        dir_tbl.push_back(with_want(finger_row(0, 4095, 0, 2, 2, 3, 0),
                                    -32768, 540, 2, 2, 0));
        dir_tbl.push_back(reg_row(REG_MODE, '0));
        dir_tbl.push_back(with_want(finger_row(1, 4095, 4095, 4, 1, 1, 1),
                                    32767, 32767, 4, 1, 1));
        // Edge snap with hysteresis: latch, hold inside the off band, release
        dir_tbl.push_back(reg_row(REG_MAX_X, CFG_DATA_W'(MAX_RESET)));
        dir_tbl.push_back(reg_row(REG_MAX_Y, CFG_DATA_W'(MAX_RESET)));
        dir_tbl.push_back(reg_row(REG_TH_X, CFG_DATA_W'(pack_th(100, 150, 4000, 3900))));
        dir_tbl.push_back(reg_row(REG_TH_Y, CFG_DATA_W'(pack_th(200, 260, 3800, 3700))));
        dir_tbl.push_back(reg_row(REG_SNAP, pack_targets(-8192, 8191, 0, 4095)));
        dir_tbl.push_back(reg_row(REG_MODE, CFG_DATA_W'(MODE_SNAP)));
        dir_tbl.push_back(finger_row(0, 50, 2000, 10, 3, 4, 0));
        dir_tbl.push_back(finger_row(0, 120, 3850, 11, 4, 4, 0));
        dir_tbl.push_back(finger_row(1, 120, 3750, 12, 5, 4, 1));
        dir_tbl.push_back(finger_row(0, 200, 3750, 13, 6, 4, 0));
        dir_tbl.push_back(finger_row(0, 4095, 3650, 14, 7, 4, 0));
        dir_tbl.push_back(finger_row(0, 3950, 0, 15, 8, 4, 1));
        dir_tbl.push_back(finger_row(1, 0, 4095, 16, 9, 4, 0));
        dir_tbl.push_back(finger_row(0, 3899, 230, 17, 10, 4, 0));
        dir_tbl.push_back(finger_row(1, 3950, 100, 18, 11, 4, 1));
        // Everything on: mirror, snap and swap together
        dir_tbl.push_back(reg_row(REG_MODE, CFG_DATA_W'(MODE_ALL)));
        dir_tbl.push_back(finger_row(0, 4095, 0, 19, 12, 13, 0));
        dir_tbl.push_back(finger_row(1, 2000, 2000, 20, 14, 15, 0));
        dir_tbl.push_back(finger_row(0, 10, 4000, 21, 15, 14, 1));
        // Writes past the last register must change nothing
        dir_tbl.push_back(reg_row(REG_SPARE_6, '1));
        dir_tbl.push_back(reg_row(REG_SPARE_7, '1));
        dir_tbl.push_back(finger_row(1, 3000, 1000, 22, 0, 15, 1));

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].is_write)
            begin
                settle_block();
                write_reg(dir_tbl[i].idx, dir_tbl[i].data);
            end
            else
            begin
                cfg_we <= 1'b0;
                send_finger(dir_tbl[i].smp, dir_tbl[i].fixed, dir_tbl[i].want);
            end
        end

        // Random phases. The first few pin the extremes of the settings; the
        // rest draw them. Most items follow a per-slot finger trace that wanders
        // and jumps to the edges so the hysteresis bands get crossed both ways.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle_block();
            rnd = {$urandom, $urandom};
            case (ph)
                0:       mode_sel = '0;
                1:       mode_sel = MODE_ALL;
                default: mode_sel = MODE_W'($urandom)
                                    | (($urandom_range(0, 3) != 0) ? MODE_SNAP : '0);
            endcase
            mx = pick_max();
            my = pick_max();
            if (ph == 2)
            begin
                mx = COORD_W'(1);
                my = COORD_W'(1);
            end
            if (ph == 3)
            begin
                mx = '0;
                my = MAX_RESET;
            end
            thx = pick_thresholds();
            thy = pick_thresholds();
            if (ph == 4)
            begin
                thx = '1;
                thy = '1;
            end
            if (ph == 5)
            begin
                thx = '0;
                thy = '0;
            end
            tgts = (ph == 1) ? pack_targets(-8192, 8191, -8192, 8191) : rnd[SNAP_W-1:0];

            write_reg(REG_MODE, CFG_DATA_W'(mode_sel));
            write_reg(REG_MAX_X, CFG_DATA_W'(mx));
            write_reg(REG_MAX_Y, CFG_DATA_W'(my));
            write_reg(REG_TH_X, CFG_DATA_W'(thx));
            write_reg(REG_TH_Y, CFG_DATA_W'(thy));
            write_reg(REG_SNAP, tgts);
            if ($urandom_range(0, 1) != 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
                          CFG_DATA_W'({$urandom, $urandom}));
            cfg_we <= 1'b0;

            // one phase runs the sender flat out
            sender_steady = (ph == 6);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick   = int'($urandom_range(0, 9));
                f.slot = SLOT_W'($urandom_range(0, FINGER_SLOTS - 1));
                s      = int'(f.slot);
                if (pick < 7)
                begin
                    if (pick == 6)
                    begin
                        trace_x[s] = ($urandom_range(0, 1) != 0)
                                     ? int'($urandom_range(0, 400))
                                     : int'($urandom_range(3700, COORD_TOP));
                        trace_y[s] = ($urandom_range(0, 1) != 0)
                                     ? int'($urandom_range(0, 400))
                                     : int'($urandom_range(3700, COORD_TOP));
                    end
                    else
                    begin
                        trace_x[s] = trace_x[s] + int'($urandom_range(0, 160)) - 80;
                        trace_y[s] = trace_y[s] + int'($urandom_range(0, 160)) - 80;
                    end
                    if (trace_x[s] < 0)
                        trace_x[s] = 0;
                    if (trace_x[s] > COORD_TOP)
                        trace_x[s] = COORD_TOP;
                    if (trace_y[s] < 0)
                        trace_y[s] = 0;
                    if (trace_y[s] > COORD_TOP)
                        trace_y[s] = COORD_TOP;
                    f.raw_x = COORD_W'(trace_x[s]);
                    f.raw_y = COORD_W'(trace_y[s]);
                end
                else
                begin
                    f.raw_x = COORD_W'($urandom);
                    f.raw_y = COORD_W'($urandom);
                end
                f.pressure  = PRESS_W'($urandom);
                f.width_x   = NIB_W'($urandom);
                f.width_y   = NIB_W'($urandom);
                f.frame_end = ($urandom_range(0, 1) != 0);
                send_finger(f, 1'b0, '0);
            end
        end

        // Let everything owed come back, then give any stray result time to show
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_touch.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard: ends the run with a mismatch if the stimulus never finishes
    initial
    begin : watchdog
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
